// ===== rtl/dtti_pkg.sv =====
// Package for the decimal text to integer parser.
// Holds item kinds, parse phases, mode codes, character codes and the queue entry type.
// No dependencies.
package dtti_pkg;

	localparam int DEFAULT_COUNT_BITS = 16;
	localparam int DEFAULT_FIFO_DEPTH = 4;

	localparam int VALUE_W = 64;
	localparam int CONS_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int MODE_W  = 2;
	localparam int DIGIT_W = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = VALUE_W + CONS_W;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

	localparam logic [MODE_W-1:0] MODE_STRICT_I32 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STRICT_I64 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCAN_I64   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SCAN_U64   = 2'd3;

	typedef enum logic [1:0] {
		K_DIGIT,
		K_MINUS,
		K_PLUS,
		K_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_RUN,
		PH_STOP,
		PH_FAIL
	} phase_t;

	typedef struct packed {
		kind_t                    kind;
		logic [DIGIT_W-1:0]       dval;
		logic                     last;
		logic                     empty;
		logic [MODE_W-1:0]        mode;
	} item_t;

endpackage

// ===== rtl/dtti_front.sv =====
// Front end: takes input beats and classifies each byte under the current mode.
// Depends on dtti_pkg; pushes item_t entries into dtti_fifo.
module dtti_front import dtti_pkg::*; (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] char_in
	input  logic                  s_tlast,
	input  logic                  s_tuser,   // [0] empty_string
	input  logic [MODE_W-1:0]     mode,
	input  logic                  full,
	output logic                  push,
	output item_t                 item
);

	logic [CHAR_W-1:0] c;
	logic              is_digit;
	logic              sign_ok;

	assign c        = s_tdata[CHAR_W-1:0];
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign sign_ok  = (mode != MODE_SCAN_U64);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		item.dval  = DIGIT_W'(c - CH_ZERO);
		item.last  = s_tlast;
		item.empty = s_tuser;
		item.mode  = mode;
		if (is_digit) begin
			item.kind = K_DIGIT;
		end else if (sign_ok && c == CH_MINUS) begin
			item.kind = K_MINUS;
		end else if (sign_ok && c == CH_PLUS) begin
			item.kind = K_PLUS;
		end else begin
			item.kind = K_OTHER;
		end
	end

endmodule

// ===== rtl/dtti_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on dtti_pkg for item_t.
module dtti_fifo import dtti_pkg::*; #(
	parameter int DEPTH = DEFAULT_FIFO_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output logic  rd_valid,
	output item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/dtti_back.sv =====
// Back end: runs the parse state per item, captures the finished string, and
// forms the result in the output register. Depends on dtti_pkg.
module dtti_back import dtti_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hd_valid,
	input  item_t                  hd_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [63:0] value, [79:64] consumed
	output logic                   m_tuser   // [0] ok
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// string state
	logic [VALUE_W-1:0]    acc_q;
	logic                  neg_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic                  have_q;
	phase_t                phase_q;

	logic [VALUE_W-1:0]    acc_n;
	logic                  neg_n;
	logic [COUNT_BITS-1:0] pos_n;
	logic                  have_n;
	phase_t                phase_n;
	logic [COUNT_BITS-1:0] pos_inc;
	logic [VALUE_W-1:0]    acc_x10;
	logic                  strict;
	logic                  fin;
	logic                  ok_n;

	// finished string, stage 1
	logic                  fin_v_s1;
	logic [VALUE_W-1:0]    acc_s1;
	logic                  neg_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic                  ok_s1;
	logic [COUNT_BITS-1:0] pos_s1;
	logic                  fin_move;

	// output register
	logic                  out_v_q;
	logic [VALUE_W-1:0]    value_q;
	logic [CONS_W-1:0]     cons_q;
	logic                  ok_q;
	logic [VALUE_W-1:0]    value_d;
	logic [VALUE_W-1:0]    signed_acc;
	logic [CONS_W-1:0]     cons_sat;

	assign fin      = hd_item.empty || hd_item.last;
	assign fin_move = fin_v_s1 && (!out_v_q || m_tready);
	assign pop      = hd_valid && (!fin || !fin_v_s1 || fin_move);
	assign strict   = (hd_item.mode == MODE_STRICT_I32) || (hd_item.mode == MODE_STRICT_I64);
	assign pos_inc  = (pos_q == CNT_MAX) ? pos_q : pos_q + 1'b1;
	assign acc_x10  = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
		+ VALUE_W'(hd_item.dval);

	// next state
	always_comb begin
		acc_n   = acc_q;
		neg_n   = neg_q;
		pos_n   = pos_q;
		have_n  = have_q;
		phase_n = phase_q;
		case (phase_q)
			PH_START: begin
				case (hd_item.kind)
					K_DIGIT: begin
						acc_n   = acc_x10;
						have_n  = 1'b1;
						pos_n   = pos_inc;
						phase_n = PH_RUN;
					end
					K_MINUS: begin
						neg_n   = 1'b1;
						pos_n   = pos_inc;
						phase_n = PH_RUN;
					end
					K_PLUS: begin
						pos_n   = pos_inc;
						phase_n = PH_RUN;
					end
					default: phase_n = PH_FAIL;
				endcase
			end
			PH_RUN: begin
				if (hd_item.kind == K_DIGIT) begin
					acc_n   = acc_x10;
					have_n  = 1'b1;
					pos_n   = pos_inc;
				end else if (strict || !have_q) begin
					phase_n = PH_FAIL;
				end else begin
					phase_n = PH_STOP;
				end
			end
			default: phase_n = phase_q;
		endcase
	end

	// string outcome
	always_comb begin
		ok_n = !hd_item.empty && have_n && (phase_n == PH_RUN || phase_n == PH_STOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			pos_q   <= '0;
			have_q  <= 1'b0;
			phase_q <= PH_START;
		end else if (pop) begin
			if (fin) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				pos_q   <= '0;
				have_q  <= 1'b0;
				phase_q <= PH_START;
			end else begin
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				pos_q   <= pos_n;
				have_q  <= have_n;
				phase_q <= phase_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (pop && fin) begin
			fin_v_s1 <= 1'b1;
		end else if (fin_move) begin
			fin_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fin) begin
			acc_s1  <= acc_n;
			neg_s1  <= neg_n;
			mode_s1 <= hd_item.mode;
			ok_s1   <= ok_n;
			pos_s1  <= pos_n;
		end
	end

	// result forming
	always_comb begin
		signed_acc = (neg_s1 && mode_s1 != MODE_SCAN_U64) ? (VALUE_W'(0) - acc_s1) : acc_s1;
		if (mode_s1 == MODE_STRICT_I32) begin
			signed_acc = {{(VALUE_W/2){signed_acc[VALUE_W/2-1]}}, signed_acc[VALUE_W/2-1:0]};
		end
		value_d = ok_s1 ? signed_acc : '0;
	end

	generate
		if (COUNT_BITS > CONS_W) begin : g_sat
			assign cons_sat = (pos_s1[COUNT_BITS-1:CONS_W] != '0) ? '1 : pos_s1[CONS_W-1:0];
		end else begin : g_ext
			assign cons_sat = CONS_W'(pos_s1);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fin_move) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_move) begin
			value_q <= value_d;
			cons_q  <= ok_s1 ? cons_sat : '0;
			ok_q    <= ok_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {cons_q, value_q};
	assign m_tuser  = ok_q;

	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop && fin |-> !fin_v_s1 || fin_move)
		else $error("finished string popped onto an occupied slot");

	a_fin_captured: assert property (@(posedge clk) disable iff (!arst_n)
		pop && fin |=> fin_v_s1)
		else $error("finished string not captured");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("failed result carries nonzero data");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && fin |=> phase_q == PH_START && !have_q && pos_q == '0)
		else $error("string state not cleared after end of string");

endmodule

// ===== rtl/decimal_text_to_integer.sv =====
// Decimal text to integer parser, top level.
// Instantiates dtti_front, dtti_fifo and dtti_back; depends on dtti_pkg.
//
// Takes one string byte per beat and returns one result beat per string, at
// the beat with tlast set or at a beat flagged empty. Throughput is one byte
// per clock while m_tready takes results, set by the back end's combinational
// multiply-by-ten-and-add on the 64-bit accumulator. The final byte passes
// the queue, end-of-string capture and output register before m_tvalid rises.
// parse_mode is sampled per byte; write it only between strings.
module decimal_text_to_integer import dtti_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
	parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [MODE_W-1:0]      cfg_wr_data,  // parse_mode
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,      // [7:0] char_in
	input  logic                   s_tlast,
	input  logic                   s_tuser,      // [0] empty_string
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,      // [63:0] value, [79:64] consumed
	output logic                   m_tuser       // [0] ok
);

	logic [MODE_W-1:0] mode_q;
	logic              full;
	logic              push;
	item_t             wr_item;
	logic              pop;
	logic              hd_valid;
	item_t             hd_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STRICT_I32;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	dtti_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.mode     (mode_q),
		.full     (full),
		.push     (push),
		.item     (wr_item)
	);

	dtti_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (full),
		.pop      (pop),
		.rd_valid (hd_valid),
		.rd_item  (hd_item)
	);

	dtti_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (hd_valid),
		.hd_item  (hd_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== sim/decimal_text_to_integer_test.sv =====
// Self-checking testbench for decimal_text_to_integer: streams strings through the block,
// predicts each parse result on its own, compares field by field. Depends on dtti_pkg.
`timescale 1ns / 100ps

module decimal_text_to_integer_test;
	import dtti_pkg::*;

	localparam int CNT_MAX = (1 << DEFAULT_COUNT_BITS) - 1;
	localparam int RANDOM_BEATS = 1150;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              lst;
		logic              emp;
	} text_beat_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               ok;
		logic [CONS_W-1:0]  consumed;
	} parse_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [MODE_W-1:0]      cfg_wr_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	text_beat_t    text_q[$];
	parse_result_t expected_parses[$];
	parse_result_t head;
	int            errors = 0;
	int            beats_queued = 0;
	int            results_seen = 0;
	int            next_hold = 40;
	int            hold_left = 0;
	int            tx_gap = 0;
	int            rx_gap = 0;
	bit            tx_calm = 1'b0;
	bit            rx_calm = 1'b0;

	// predictor state
	logic [MODE_W-1:0]  mode_m = MODE_STRICT_I32;
	logic [VALUE_W-1:0] acc_m = '0;
	logic               neg_m = 1'b0;
	int                 pos_m = 0;
	int                 dig_m = 0;
	phase_t             ph_m = PH_START;

	decimal_text_to_integer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int bump(input int v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 1;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string field, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		errors++;
		if (errors <= 50)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
	endtask

	task automatic take_digit(input logic [CHAR_W-1:0] ch);
		acc_m = acc_m * 64'd10 + VALUE_W'(ch - CH_ZERO);
		dig_m = bump(dig_m);
		pos_m = bump(pos_m);
		ph_m = PH_RUN;
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic lst, input logic emp);
		parse_result_t r;
		logic [VALUE_W-1:0] a;
		logic is_dig;
		r = '0;
		if (!emp) begin
			is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
			case (ph_m)
			PH_START: begin
				if (is_dig) begin
					take_digit(ch);
				end else if (mode_m != MODE_SCAN_U64 && ch == CH_MINUS) begin
					neg_m = 1'b1;
					pos_m = bump(pos_m);
					ph_m = PH_RUN;
				end else if (mode_m != MODE_SCAN_U64 && ch == CH_PLUS) begin
					pos_m = bump(pos_m);
					ph_m = PH_RUN;
				end else begin
					ph_m = PH_FAIL;
				end
			end
			PH_RUN: begin
				if (is_dig)
					take_digit(ch);
				else if (mode_m == MODE_STRICT_I32 || mode_m == MODE_STRICT_I64 || dig_m == 0)
					ph_m = PH_FAIL;
				else
					ph_m = PH_STOP;
			end
			default: ;
			endcase
			if (!lst)
				return;
			r.ok = (ph_m == PH_RUN || ph_m == PH_STOP) && dig_m != 0;
		end
		if (r.ok) begin
			a = acc_m;
			if (neg_m && mode_m != MODE_SCAN_U64)
				a = -a;
			if (mode_m == MODE_STRICT_I32)
				a = {{32{a[31]}}, a[31:0]};
			r.value = a;
			r.consumed = CONS_W'(pos_m > 16'hFFFF ? 16'hFFFF : pos_m);
		end
		expected_parses.push_back(r);
		acc_m = '0;
		neg_m = 1'b0;
		pos_m = 0;
		dig_m = 0;
		ph_m = PH_START;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_char(s_tdata, s_tlast, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (text_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_q[0].ch;
					s_tlast <= text_q[0].lst;
					s_tuser <= text_q[0].emp;
					void'(text_q.pop_front());
					tx_gap <= pick_gap(tx_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold && text_q.size() > 30) begin
			hold_left <= 120;
			next_hold <= next_hold + 100;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_parses.size() == 0) begin
					report("unexpected result", m_tdata[VALUE_W-1:0], '0);
				end else begin
					head = expected_parses.pop_front();
					if (m_tdata[VALUE_W-1:0] !== head.value)
						report("value", m_tdata[VALUE_W-1:0], head.value);
					if (m_tuser !== head.ok)
						report("ok", VALUE_W'(m_tuser), VALUE_W'(head.ok));
					if (m_tdata[VALUE_W +: CONS_W] !== head.consumed)
						report("consumed", VALUE_W'(m_tdata[VALUE_W +: CONS_W]),
							VALUE_W'(head.consumed));
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap <= pick_gap(rx_calm);
			end
		end
	end

	task automatic put_beat(input logic [CHAR_W-1:0] ch, input logic lst, input logic emp);
		text_beat_t b;
		b.ch = ch;
		b.lst = lst;
		b.emp = emp;
		text_q.push_back(b);
		beats_queued++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_beat(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic put_bytes(input logic [CHAR_W-1:0] b[$], input bit with_last);
		for (int i = 0; i < b.size(); i++)
			put_beat(b[i], with_last && i == b.size() - 1, 1'b0);
	endtask

	function automatic logic [CHAR_W-1:0] junk_char();
		case ($urandom_range(0, 5))
		0: return 8'h2F;
		1: return 8'h3A;
		2: return CH_MINUS;
		3: return CH_PLUS;
		default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic gen_string();
		logic [CHAR_W-1:0] b[$];
		int r, n, k;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			k = $urandom_range(0, 3);
			if (k == 1)
				b.push_back(CH_MINUS);
			else if (k == 2)
				b.push_back(CH_PLUS);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
			k = $urandom_range(0, 5);
			repeat (n)
				b.push_back(k == 0 ? CH_NINE : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4))
					b.push_back(($urandom_range(0, 2) == 0) ? CH_ZERO : junk_char());
			put_bytes(b, 1'b1);
		end else if (r < 82) begin
			repeat ($urandom_range(1, 6))
				b.push_back(junk_char());
			put_bytes(b, 1'b1);
		end else if (r < 89) begin
			b.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
			repeat ($urandom_range(0, 2))
				b.push_back(junk_char());
			put_bytes(b, 1'b1);
		end else if (r < 95) begin
			// partial string cut short by an empty beat
			repeat ($urandom_range(1, 5))
				b.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			put_bytes(b, 1'b0);
			put_beat(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			put_beat(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_m = m;
	endtask

	task automatic drain();
		while (text_q.size() != 0 || s_tvalid || expected_parses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int base;
		int phase_no;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(MODE_STRICT_I32);
		put_text("-9");
		put_text("1a");
		put_beat(8'hFF, 1'b0, 1'b1);
		put_text("+");
		drain();

		write_mode(MODE_STRICT_I64);
		put_text("09");
		put_beat(8'h00, 1'b1, 1'b0);
		drain();

		write_mode(MODE_SCAN_I64);
		put_text("12z9");
		put_text("-7-");
		put_text("+x");
		drain();

		write_mode(MODE_SCAN_U64);
		put_text("-5");
		put_beat(CH_NINE - 8'd2, 1'b0, 1'b0);
		put_beat(8'hFF, 1'b1, 1'b0);
		drain();

		base = beats_queued;
		phase_no = 0;
		while (beats_queued - base < RANDOM_BEATS) begin
			write_mode(phase_no < 4 ? MODE_W'(phase_no) : MODE_W'($urandom_range(0, 3)));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(20, 35))
				gen_string();
			drain();
			phase_no++;
		end

		if (errors == 0)
			$display("[decimal_text_to_integer] OK");
		else
			$display("[decimal_text_to_integer] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[decimal_text_to_integer] ERROR");
		$finish;
	end

endmodule
